[src/pcq_pkg.sv]
// Package: shared types and constants for the press/click/long-press qualifier.
`default_nettype none

package pcq_pkg;

    localparam int TimeW    = 32;
    localparam int SampleW  = 12;
    localparam int MsgW     = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // Event codes carried on the output tuser
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CLICK = 2'd1,
        EV_LONG  = 2'd2,
        EV_SLEEP = 2'd3
    } event_kind_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_PRESS_TH   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RELEASE_TH = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_LONG_TIME  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SLEEP_TIME = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_INTERVAL   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MSG_COUNT  = 3'd5;

    typedef struct packed {
        logic [SampleW-1:0] press_threshold;
        logic [SampleW-1:0] release_threshold;
        logic [TimeW-1:0]   long_press_time;
        logic [TimeW-1:0]   sleep_timeout;
        logic [TimeW-1:0]   sample_interval;
        logic [MsgW-1:0]    message_count;
    } cfg_t;

    typedef struct packed {
        event_kind_t       event_kind;
        logic [MsgW-1:0]   message_index;
        logic              is_sleeping;
        logic              is_pressed;
    } result_t;

endpackage

`default_nettype wire

[src/pcq_cfg.sv]
// Configuration register file for the qualifier thresholds and timers.
`default_nettype none

module pcq_cfg
    import pcq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    // Register writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_threshold   <= 12'd3300;
            cfg_reg.release_threshold <= 12'd3980;
            cfg_reg.long_press_time   <= 32'd2000;
            cfg_reg.sleep_timeout     <= 32'd120000;
            cfg_reg.sample_interval   <= 32'd50;
            cfg_reg.message_count     <= 8'd18;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESS_TH:   cfg_reg.press_threshold   <= cfg_data[SampleW-1:0];
                REG_RELEASE_TH: cfg_reg.release_threshold <= cfg_data[SampleW-1:0];
                REG_LONG_TIME:  cfg_reg.long_press_time   <= cfg_data[TimeW-1:0];
                REG_SLEEP_TIME: cfg_reg.sleep_timeout     <= cfg_data[TimeW-1:0];
                REG_INTERVAL:   cfg_reg.sample_interval   <= cfg_data[TimeW-1:0];
                REG_MSG_COUNT:  cfg_reg.message_count     <= cfg_data[MsgW-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/pcq_core.sv]
// Press state, timers and message index: next-state and result logic for one sample.
`default_nettype none

module pcq_core
    import pcq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               item_take,
    input  wire logic [TimeW-1:0]   now_time,
    input  wire logic [SampleW-1:0] force_sample,
    output logic                    keep,
    output result_t                 result
);

    logic              press_active_reg, press_active_next;
    logic              long_fired_reg,   long_fired_next;
    logic              asleep_reg,       asleep_next;
    logic [MsgW-1:0]   cur_msg_reg,      cur_msg_next;
    logic [TimeW-1:0]  last_touch_reg,   last_touch_next;
    logic [TimeW-1:0]  last_accept_reg;
    logic [TimeW-1:0]  press_begin_reg,  press_begin_next;

    logic              is_press;
    logic              is_release;
    logic [TimeW-1:0]  held_time;
    logic [TimeW-1:0]  idle_time;
    logic [MsgW:0]     click_idx;
    logic              small_count;
    event_kind_t       kind;

    // Rate gate: drop samples that come too soon after the last kept one
    assign keep = ((now_time - last_accept_reg) >= cfg.sample_interval);

    assign is_press   = (force_sample <= cfg.press_threshold);
    assign is_release = (force_sample >= cfg.release_threshold);
    // Held time is zero on the first sample of a press
    assign held_time  = press_active_reg ? (now_time - press_begin_reg) : '0;
    assign small_count = (cfg.message_count < 8'd2);

    // Click advances the index, wrapping back to 1
    always_comb
    begin
        click_idx = {1'b0, cur_msg_reg} + 9'd1;
        if (click_idx >= {1'b0, cfg.message_count})
        begin
            click_idx = 9'd1;
        end
    end

    // Next state
    always_comb
    begin
        press_active_next = press_active_reg;
        long_fired_next   = long_fired_reg;
        asleep_next       = asleep_reg;
        cur_msg_next      = cur_msg_reg;
        last_touch_next   = last_touch_reg;
        press_begin_next  = press_begin_reg;
        kind              = EV_NONE;

        if (is_press)
        begin
            press_active_next = 1'b1;
            last_touch_next   = now_time;
            if (!press_active_reg)
            begin
                long_fired_next  = 1'b0;
                press_begin_next = now_time;
            end
            if (!long_fired_next && (held_time >= cfg.long_press_time))
            begin
                long_fired_next = 1'b1;
                asleep_next     = 1'b0;
                kind            = EV_LONG;
            end
        end
        else if (press_active_reg && is_release)
        begin
            press_active_next = 1'b0;
            long_fired_next   = 1'b0;
            last_touch_next   = now_time;
            if (!long_fired_reg)
            begin
                kind = EV_CLICK;
                if (small_count)
                begin
                    cur_msg_next = '0;
                    asleep_next  = 1'b1;
                end
                else
                begin
                    cur_msg_next = click_idx[MsgW-1:0];
                    asleep_next  = 1'b0;
                end
            end
        end

        // Idle timeout back to the sleep message
        if (!asleep_next && !press_active_next &&
            (idle_time >= cfg.sleep_timeout))
        begin
            cur_msg_next = '0;
            asleep_next  = 1'b1;
            kind         = EV_SLEEP;
        end
    end

    assign idle_time = now_time - last_touch_next;

    assign result.event_kind    = kind;
    assign result.message_index = cur_msg_next;
    assign result.is_sleeping   = asleep_next;
    assign result.is_pressed    = press_active_next;

    // State registers, updated only on kept samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_active_reg <= 1'b0;
            long_fired_reg   <= 1'b0;
            asleep_reg       <= 1'b1;
            cur_msg_reg      <= '0;
            last_touch_reg   <= '0;
            last_accept_reg  <= '0;
            press_begin_reg  <= '0;
        end
        else if (item_take && keep)
        begin
            press_active_reg <= press_active_next;
            long_fired_reg   <= long_fired_next;
            asleep_reg       <= asleep_next;
            cur_msg_reg      <= cur_msg_next;
            last_touch_reg   <= last_touch_next;
            last_accept_reg  <= now_time;
            press_begin_reg  <= press_begin_next;
        end
    end

`ifndef ASSERT_OFF
    a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        long_fired_reg |-> press_active_reg)
        else $error("long-press flag set without an active press");

    a_asleep_msg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        asleep_reg |-> (cur_msg_reg == '0))
        else $error("asleep with a nonzero message index");

    a_sleep_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && keep && (result.event_kind == EV_SLEEP)) |->
        ((result.message_index == '0) && result.is_sleeping && !result.is_pressed))
        else $error("sleep event with inconsistent result fields");

    a_drop_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && !keep) |=>
        ($stable(press_active_reg) && $stable(cur_msg_reg) && $stable(last_accept_reg)))
        else $error("dropped sample changed the state");
`endif

endmodule

`default_nettype wire

[src/press_click_longpress_qualifier.sv]
// Top level: stream ports, input register, qualifier core and result register.
// A kept request passes the input register and then the result register, where it waits for m_tready.
// Throughput: one request per cycle unless the output stalls; the state update is one compare/subtract pass.
// Requests arriving before the sample interval has elapsed are dropped, no result.
// Reset (rst_n, async, active low): idle, asleep at index 0, registers at defaults.
// No clearing pass; the block accepts requests right after reset.
`default_nettype none

module press_click_longpress_qualifier
    import pcq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration write port
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    // input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [47:0]         s_tdata,   // [31:0] now_time, [43:32] force_sample
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,   // [7:0] message_index, [8] is_sleeping,
                                                // [9] is_pressed
    output logic [1:0]               m_tuser    // [1:0] event_kind
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [TimeW-1:0]   now_reg;
    logic [SampleW-1:0] sample_reg;
    logic               keep;
    logic               take;
    logic               out_free;
    logic               out_load;
    logic               s_fire;
    result_t            result;
    logic               out_valid_reg;
    result_t            out_reg;

    pcq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_take    (take),
        .now_time     (now_reg),
        .force_sample (sample_reg),
        .keep         (keep),
        .result       (result)
    );

    // Handshake: dropped samples need no result slot
    assign out_free = !out_valid_reg || m_tready;
    assign take     = in_valid_reg && (!keep || out_free);
    assign out_load = take && keep;
    assign s_tready = !in_valid_reg || take;
    assign s_fire   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            now_reg    <= s_tdata[TimeW-1:0];
            sample_reg <= s_tdata[TimeW+SampleW-1:TimeW];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {6'd0, out_reg.is_pressed, out_reg.is_sleeping, out_reg.message_index};

endmodule

`default_nettype wire
